### hw/rtl/tksel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k score selector package
// Shared widths, register indexes and the ranking function of the selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

	// Slots of the kept list; only the first DEPTH of them can ever hold an
	// entry, because the effective count is also capped at sixteen.
	localparam int SLOTS = 16;
	localparam int DEPTH = (SLOTS < 16) ? SLOTS : 16;

	localparam int CNT_W  = 5;
	localparam int RANK_W = 4;
	localparam int IDX_W  = 2;

	typedef logic signed [31:0] score_t;
	typedef logic [31:0]        doc_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [RANK_W-1:0]  rank_t;
	typedef logic [IDX_W-1:0]   cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_REQUESTED = 2'd0;
	localparam cfg_idx_t CFG_MAX       = 2'd1;
	localparam cfg_idx_t CFG_DEFAULT   = 2'd2;

	localparam count_t RST_REQUESTED = 5'd0;
	localparam count_t RST_MAX       = 5'd16;
	localparam count_t RST_DEFAULT   = 5'd10;
	localparam count_t COUNT_CAP     = CNT_W'(DEPTH);

	// True when entry a ranks strictly ahead of entry b: higher score first,
	// then lower document id.
	function automatic logic ranks_before(score_t sa, doc_t da, score_t sb, doc_t db);
		logic res;
		if (sa != sb) begin
			res = (sa > sb);
		end else begin
			res = (da < db);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/top_k_score_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k score selector
// A candidate is folded into the kept list in the cycle it is accepted. An
// accepted end-of-set item starts a drain; results go to the output register
// whenever it is free. Input: one transaction per cycle while no run drains;
// a run emits max(1, kept entries) results, one per cycle unless out_ready stalls.
// Reset: arst_n clears the kept count, the drain and output control, and loads
// the register defaults (request 0, maximum 16, default 10).
// ----------------------------------------------------------------------------
module top_k_score_selector (
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_we,
	input  wire tksel_pkg::cfg_idx_t       cfg_idx,
	input  wire tksel_pkg::count_t         cfg_wdata,

	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      has_candidate,
	input  wire tksel_pkg::score_t         cand_score,
	input  wire tksel_pkg::doc_t           cand_doc,
	input  wire logic                      end_of_set,

	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           found,
	output tksel_pkg::rank_t               rank_pos,
	output tksel_pkg::doc_t                out_doc,
	output tksel_pkg::score_t              out_score,
	output logic                           run_last
);

	localparam int DEPTH = tksel_pkg::DEPTH;

	// Configuration registers.
	tksel_pkg::count_t req_q;
	tksel_pkg::count_t max_q;
	tksel_pkg::count_t dflt_q;

	// The kept list, always held in rank order, best entry in slot zero. Every
	// slot is compared against the newcomer in parallel and the list moves as
	// a shift line, so no slot is ever read at a computed address.
	tksel_pkg::score_t kept_score_q [DEPTH];
	tksel_pkg::doc_t   kept_doc_q   [DEPTH];
	tksel_pkg::count_t kept_total_q;

	// Drain control: while a run is being emitted the input is held off.
	logic              drain_q;
	tksel_pkg::rank_t  rank_q;

	// Output register.
	logic              out_valid_q;
	logic              found_q;
	tksel_pkg::rank_t  rank_pos_q;
	tksel_pkg::doc_t   out_doc_q;
	tksel_pkg::score_t out_score_q;
	logic              run_last_q;

	tksel_pkg::count_t n_clamp;
	tksel_pkg::count_t n_eff;
	logic [DEPTH-1:0]  rb_vec;
	logic [DEPTH-1:0]  gt_vec;
	logic [DEPTH-1:0]  last_vec;
	logic [DEPTH-1:0]  pos_mask;
	logic              room;
	logic              beats_weakest;
	logic              take;
	tksel_pkg::count_t base_total;
	tksel_pkg::count_t total_ins;
	logic              in_fire;
	logic              out_load;
	logic              run_empty;

	assign in_ready = !drain_q;
	assign in_fire  = in_valid && in_ready;
	// A result is loaded whenever a run is draining and the output register is
	// free or being emptied in this very cycle.
	assign out_load  = drain_q && (!out_valid_q || out_ready);
	assign run_empty = (kept_total_q == '0);

	// Effective count: the request clamped to the maximum, the default when
	// that comes out as zero, and never more than the list can hold.
	always_comb begin
		n_clamp = (req_q > max_q) ? max_q : req_q;
		n_eff   = (n_clamp == '0) ? dflt_q : n_clamp;
		if (n_eff > tksel_pkg::COUNT_CAP) begin
			n_eff = tksel_pkg::COUNT_CAP;
		end
	end

	// Insertion decision. The list is sorted, so the per-slot "newcomer ranks
	// ahead" flags form a thermometer; its first set bit is where the newcomer
	// goes, and everything from there down moves one slot towards the tail.
	// When the list is full the weakest entry (the tail) drops out, which is
	// the lowest score and, among equal scores, the largest id.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			rb_vec[i]   = tksel_pkg::ranks_before(cand_score, cand_doc,
				kept_score_q[i], kept_doc_q[i]);
			gt_vec[i]   = (cand_score > kept_score_q[i]);
			last_vec[i] = (kept_total_q == tksel_pkg::CNT_W'(i + 1));
		end
		room          = (kept_total_q < n_eff);
		beats_weakest = |(gt_vec & last_vec);
		take          = has_candidate && (room || (!run_empty && beats_weakest));
		base_total    = room ? kept_total_q : kept_total_q - 1'b1;
		total_ins     = room ? kept_total_q + 1'b1 : kept_total_q;
		for (int i = 0; i < DEPTH; i++) begin
			pos_mask[i] = rb_vec[i] || (tksel_pkg::CNT_W'(i) >= base_total);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q        <= tksel_pkg::RST_REQUESTED;
			max_q        <= tksel_pkg::RST_MAX;
			dflt_q       <= tksel_pkg::RST_DEFAULT;
			kept_total_q <= '0;
			drain_q      <= 1'b0;
			rank_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					tksel_pkg::CFG_REQUESTED: req_q  <= cfg_wdata;
					tksel_pkg::CFG_MAX:       max_q  <= cfg_wdata;
					tksel_pkg::CFG_DEFAULT:   dflt_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (in_fire) begin
				if (take) begin
					kept_total_q <= total_ins;
				end
				if (end_of_set) begin
					drain_q <= 1'b1;
					rank_q  <= '0;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				rank_q      <= rank_q + 1'b1;
				// The final result of a run (or the single empty-set result)
				// closes the run and leaves the list empty.
				if (kept_total_q <= tksel_pkg::CNT_W'(1)) begin
					drain_q      <= 1'b0;
					kept_total_q <= '0;
				end else begin
					kept_total_q <= kept_total_q - 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Kept list and output payload. During a drain the list shifts towards
	// slot zero, one entry per result; otherwise an accepted newcomer is
	// inserted at its rank position.
	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q     <= !run_empty;
			rank_pos_q  <= rank_q;
			out_doc_q   <= run_empty ? '0 : kept_doc_q[0];
			out_score_q <= run_empty ? '0 : kept_score_q[0];
			run_last_q  <= (kept_total_q <= tksel_pkg::CNT_W'(1));
			for (int i = 0; i < DEPTH - 1; i++) begin
				kept_score_q[i] <= kept_score_q[i + 1];
				kept_doc_q[i]   <= kept_doc_q[i + 1];
			end
		end else if (in_fire && take) begin
			if (pos_mask[0]) begin
				kept_score_q[0] <= cand_score;
				kept_doc_q[0]   <= cand_doc;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (pos_mask[i - 1]) begin
					kept_score_q[i] <= kept_score_q[i - 1];
					kept_doc_q[i]   <= kept_doc_q[i - 1];
				end else if (pos_mask[i]) begin
					kept_score_q[i] <= cand_score;
					kept_doc_q[i]   <= cand_doc;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign rank_pos  = rank_pos_q;
	assign out_doc   = out_doc_q;
	assign out_score = out_score_q;
	assign run_last  = run_last_q;

`ifndef SYNTH
	// The kept count never exceeds the capacity of the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		kept_total_q <= tksel_pkg::COUNT_CAP)
		else $error("kept count beyond list capacity");

	// Loading the final result of a run ends the drain with an empty list.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (kept_total_q <= tksel_pkg::CNT_W'(1)))
		|=> (!drain_q && kept_total_q == '0 && out_valid_q && run_last_q))
		else $error("run did not close after its final result");

	// An empty-set result is always the only, first-ranked result of its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (run_last_q && rank_pos_q == '0))
		else $error("empty-set result not marked as sole result");

	// Each further result of a run follows its predecessor in rank order.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && drain_q && $past(out_load) && $past(drain_q))
		|=> (rank_pos_q == $past(rank_pos_q) + 1'b1))
		else $error("rank positions out of sequence");
`endif

endmodule
`default_nettype wire
